// File: hw/rtl/sorted_order_list_core_macros.svh
// Assertion macros for the sorted order list core checker.
// Expects signals named clock and reset in the scope of each use.
`ifndef SORTED_ORDER_LIST_CORE_MACROS_SVH
`define SORTED_ORDER_LIST_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SOL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SOL_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/sol_pkg.sv
// Shared types and constants for the sorted order list core.
// No dependencies; used by every module of the block but sol_ram.
`default_nettype none

package sol_pkg;

   localparam int DEPTH_DEF    = 16;
   localparam int CMD_W        = 2;
   localparam int CLIENT_W     = 16;
   localparam int AMOUNT_W     = 32;
   localparam int STATUS_W     = 3;
   localparam int ENTRY_W      = CLIENT_W + AMOUNT_W;

   // Request commands
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_LIST   = 2'd2
   } cmd_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL      = 3'd2,
      ST_ENTRY     = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_EV,
      S_DEL_RD,
      S_DEL_EV,
      S_LIST
   } state_type;

   // Index register operations
   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_COUNT,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load;       // capture request key, clear found flag
      idx_op_type idx_op;
      logic       rd_en;
      logic       rd_prev;    // read at idx-1 instead of idx
      logic       wr_en;
      logic       wr_new;     // write request key instead of read data
      logic       wr_prev;    // write at idx-1 instead of idx
      logic       cnt_inc;
      logic       cnt_dec;
      logic       found_set;
      logic       list_rd;    // read feeds a list response
      logic       rsp_en;     // single response with rsp_status
      status_type rsp_status;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic idx_zero;
      logic idx_end;      // idx equals entry count
      logic rd_greater;   // read amount strictly above key
      logic rd_match;     // read client and amount equal key
      logic found;
      logic list_pend;    // list responses still in flight
   } dp_sts_type;

endpackage

`default_nettype wire

// File: hw/rtl/sol_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module sol_ram #(
   parameter int WIDTH  = 48,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/sol_datapath.sv
// Datapath of the sorted order list: entry RAM, index, count, key and
// response registers. Depends on sol_pkg and sol_ram.
`default_nettype none

module sol_datapath #(
   parameter int DEPTH = sol_pkg::DEPTH_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic        [sol_pkg::CLIENT_W-1:0] req_client,
   input  wire logic signed [sol_pkg::AMOUNT_W-1:0] req_amount,
   input  wire sol_pkg::dp_cmd_type                 ctrl,
   output      sol_pkg::dp_sts_type                 sts,
   output      logic                                rsp_strobe,
   output      logic        [sol_pkg::STATUS_W-1:0] rsp_status,
   output      logic        [sol_pkg::CLIENT_W-1:0] rsp_entry_client,
   output      logic signed [sol_pkg::AMOUNT_W-1:0] rsp_entry_amount,
   output      logic                                rsp_last
);

   logic        [sol_pkg::CLIENT_W-1:0] key_client_ff;
   logic signed [sol_pkg::AMOUNT_W-1:0] key_amount_ff;
   logic        [CW-1:0]                idx_ff, idx_in;
   logic        [CW-1:0]                count_ff, count_in;
   logic                                found_ff, found_in;
   logic                                pend_ff, pend_last_ff;

   logic                                rsp_strobe_ff;
   sol_pkg::status_type                 rsp_status_ff;
   logic        [sol_pkg::CLIENT_W-1:0] rsp_client_ff;
   logic signed [sol_pkg::AMOUNT_W-1:0] rsp_amount_ff;
   logic                                rsp_last_ff;

   logic        [CW-1:0]                idx_prev;
   logic        [AW-1:0]                rd_addr, wr_addr;
   logic        [sol_pkg::ENTRY_W-1:0]  wr_data, rd_data;
   logic        [sol_pkg::CLIENT_W-1:0] rd_client;
   logic signed [sol_pkg::AMOUNT_W-1:0] rd_amount;

   assign idx_prev  = idx_ff - CW'(1);
   assign rd_client = rd_data[sol_pkg::ENTRY_W-1:sol_pkg::AMOUNT_W];
   assign rd_amount = $signed(rd_data[sol_pkg::AMOUNT_W-1:0]);

   // RAM addressing and write data
   assign rd_addr = ctrl.rd_prev ? idx_prev[AW-1:0] : idx_ff[AW-1:0];
   assign wr_addr = ctrl.wr_prev ? idx_prev[AW-1:0] : idx_ff[AW-1:0];
   assign wr_data = ctrl.wr_new ? {key_client_ff, key_amount_ff} : rd_data;

   sol_ram #(
      .WIDTH  (sol_pkg::ENTRY_W),
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctrl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Index and count next values
   always_comb begin
      case (ctrl.idx_op)
         sol_pkg::IDX_ZERO:  idx_in = '0;
         sol_pkg::IDX_COUNT: idx_in = count_ff;
         sol_pkg::IDX_INC:   idx_in = idx_ff + CW'(1);
         sol_pkg::IDX_DEC:   idx_in = idx_prev;
         default:            idx_in = idx_ff;
      endcase
      count_in = count_ff;
      if (ctrl.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
      found_in = found_ff;
      if (ctrl.load) begin
         found_in = 1'b0;
      end else if (ctrl.found_set) begin
         found_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         count_ff <= '0;
         found_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         count_ff <= count_in;
         found_ff <= found_in;
         pend_ff  <= ctrl.list_rd;
      end
   end

   // Request key and list bookkeeping
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         key_client_ff <= req_client;
         key_amount_ff <= req_amount;
      end
      pend_last_ff <= ((idx_ff + CW'(1)) == count_ff);
   end

   // Response word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctrl.rsp_en | pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_en) begin
         rsp_status_ff <= ctrl.rsp_status;
         rsp_client_ff <= '0;
         rsp_amount_ff <= '0;
         rsp_last_ff   <= 1'b1;
      end else if (pend_ff) begin
         rsp_status_ff <= sol_pkg::ST_ENTRY;
         rsp_client_ff <= rd_client;
         rsp_amount_ff <= rd_amount;
         rsp_last_ff   <= pend_last_ff;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_client = rsp_client_ff;
   assign rsp_entry_amount = rsp_amount_ff;
   assign rsp_last         = rsp_last_ff;

   // Status toward the controller
   always_comb begin
      sts.count_zero = (count_ff == '0);
      sts.count_full = (count_ff == CW'(DEPTH));
      sts.idx_zero   = (idx_ff == '0);
      sts.idx_end    = (idx_ff == count_ff);
      sts.rd_greater = (rd_amount > key_amount_ff);
      sts.rd_match   = (rd_client == key_client_ff) && (rd_amount == key_amount_ff);
      sts.found      = found_ff;
      sts.list_pend  = pend_ff;
   end

endmodule

`default_nettype wire

// File: hw/rtl/sol_controller.sv
// Controller state machine of the sorted order list core.
// Depends on sol_pkg; drives the datapath through dp_cmd_type.
`default_nettype none

module sol_controller (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [sol_pkg::CMD_W-1:0]        req_cmd,
   input  wire sol_pkg::dp_sts_type              sts,
   output      sol_pkg::dp_cmd_type              ctrl,
   output      logic                             busy
);

   sol_pkg::state_type state_ff, state_in;
   logic               accept;

   assign busy   = (state_ff != sol_pkg::S_IDLE) || sts.list_pend;
   assign accept = start && !busy;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sol_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sol_pkg::S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  sol_pkg::CMD_INSERT: begin
                     if (!sts.count_full) state_in = sol_pkg::S_INS_RD;
                  end
                  sol_pkg::CMD_DELETE: state_in = sol_pkg::S_DEL_RD;
                  sol_pkg::CMD_LIST: begin
                     if (!sts.count_zero) state_in = sol_pkg::S_LIST;
                  end
                  default: state_in = sol_pkg::S_IDLE;
               endcase
            end
         end
         sol_pkg::S_INS_RD: begin
            state_in = sts.idx_zero ? sol_pkg::S_IDLE : sol_pkg::S_INS_EV;
         end
         sol_pkg::S_INS_EV: begin
            state_in = sts.rd_greater ? sol_pkg::S_IDLE : sol_pkg::S_INS_RD;
         end
         sol_pkg::S_DEL_RD: begin
            state_in = sts.idx_end ? sol_pkg::S_IDLE : sol_pkg::S_DEL_EV;
         end
         sol_pkg::S_DEL_EV: state_in = sol_pkg::S_DEL_RD;
         sol_pkg::S_LIST: begin
            if (sts.idx_end) state_in = sol_pkg::S_IDLE;
         end
         default: state_in = sol_pkg::S_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      ctrl            = '0;
      ctrl.idx_op     = sol_pkg::IDX_HOLD;
      ctrl.rsp_status = sol_pkg::ST_DONE;
      case (state_ff)
         sol_pkg::S_IDLE: begin
            if (accept) begin
               ctrl.load = 1'b1;
               case (req_cmd)
                  sol_pkg::CMD_INSERT: begin
                     if (sts.count_full) begin
                        ctrl.rsp_en     = 1'b1;
                        ctrl.rsp_status = sol_pkg::ST_FULL;
                     end else begin
                        ctrl.idx_op = sol_pkg::IDX_COUNT;
                     end
                  end
                  sol_pkg::CMD_DELETE: ctrl.idx_op = sol_pkg::IDX_ZERO;
                  sol_pkg::CMD_LIST: begin
                     if (sts.count_zero) begin
                        ctrl.rsp_en     = 1'b1;
                        ctrl.rsp_status = sol_pkg::ST_EMPTY;
                     end else begin
                        ctrl.idx_op = sol_pkg::IDX_ZERO;
                     end
                  end
                  default: ctrl.load = 1'b0;
               endcase
            end
         end
         // Insert: walk down from the tail, shifting entries up by one
         sol_pkg::S_INS_RD: begin
            if (sts.idx_zero) begin
               ctrl.wr_en   = 1'b1;
               ctrl.wr_new  = 1'b1;
               ctrl.cnt_inc = 1'b1;
               ctrl.rsp_en  = 1'b1;
            end else begin
               ctrl.rd_en   = 1'b1;
               ctrl.rd_prev = 1'b1;
            end
         end
         sol_pkg::S_INS_EV: begin
            ctrl.wr_en = 1'b1;
            if (sts.rd_greater) begin
               ctrl.wr_new  = 1'b1;
               ctrl.cnt_inc = 1'b1;
               ctrl.rsp_en  = 1'b1;
            end else begin
               ctrl.idx_op = sol_pkg::IDX_DEC;
            end
         end
         // Delete: scan from the head, shift later entries down once found
         sol_pkg::S_DEL_RD: begin
            if (sts.idx_end) begin
               ctrl.rsp_en     = 1'b1;
               ctrl.cnt_dec    = sts.found;
               ctrl.rsp_status = sts.found ? sol_pkg::ST_DONE : sol_pkg::ST_NOT_FOUND;
            end else begin
               ctrl.rd_en = 1'b1;
            end
         end
         sol_pkg::S_DEL_EV: begin
            ctrl.idx_op = sol_pkg::IDX_INC;
            if (sts.found) begin
               ctrl.wr_en   = 1'b1;
               ctrl.wr_prev = 1'b1;
            end else if (sts.rd_match) begin
               ctrl.found_set = 1'b1;
            end
         end
         // List: one read per cycle until the count is reached
         sol_pkg::S_LIST: begin
            if (!sts.idx_end) begin
               ctrl.rd_en   = 1'b1;
               ctrl.list_rd = 1'b1;
               ctrl.idx_op  = sol_pkg::IDX_INC;
            end
         end
         default: ctrl.idx_op = sol_pkg::IDX_HOLD;
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/sorted_order_list_core.sv
// Top level of the sorted order list core.
// Depends on sol_pkg, sol_controller and sol_datapath.
//
// Keeps up to DEPTH (client, amount) entries in descending amount order.
// Request channel: req_cmd, req_client, req_amount are taken at a rising edge
// where start is high and busy is low. Commands: insert, delete, list.
// Response channel: each word shows for one cycle with rsp_strobe high; the
// receiver cannot stall it. rsp_last marks the final word of a command.
// Insert and delete give one word; list gives one word per entry, or one
// empty word when the table holds nothing.
// Insert walks down from the tail until it finds its place; delete always
// scans every entry. An insert to a full table gives ST_FULL without a walk.
// List reads the entries from the head and gives one word per cycle.
// The entry RAM has one read and one write port; insert and delete spend a
// read state and an evaluate/write state per entry they touch.
// Reset clears the entry count and the controller; RAM contents are not
// cleared, only entries below the count are ever read.
`default_nettype none

module sorted_order_list_core #(
   parameter int DEPTH = sol_pkg::DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic        [sol_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic        [sol_pkg::CLIENT_W-1:0] req_client,
   input  wire logic signed [sol_pkg::AMOUNT_W-1:0] req_amount,
   output      logic                                rsp_strobe,
   output      logic        [sol_pkg::STATUS_W-1:0] rsp_status,
   output      logic        [sol_pkg::CLIENT_W-1:0] rsp_entry_client,
   output      logic signed [sol_pkg::AMOUNT_W-1:0] rsp_entry_amount,
   output      logic                                rsp_last
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   sol_pkg::dp_cmd_type ctrl;
   sol_pkg::dp_sts_type sts;

   sol_controller u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .sts     (sts),
      .ctrl    (ctrl),
      .busy    (busy)
   );

   sol_datapath #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_client       (req_client),
      .req_amount       (req_amount),
      .ctrl             (ctrl),
      .sts              (sts),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_entry_client (rsp_entry_client),
      .rsp_entry_amount (rsp_entry_amount),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// File: hw/rtl/sol_checker.sv
// Port-level assertions for the sorted order list core, bound to the top.
// Depends on sol_pkg and sorted_order_list_core_macros.svh.
`default_nettype none

`include "sorted_order_list_core_macros.svh"

module sol_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire logic                                rsp_strobe,
   input wire logic        [sol_pkg::STATUS_W-1:0] rsp_status,
   input wire logic        [sol_pkg::CLIENT_W-1:0] rsp_entry_client,
   input wire logic signed [sol_pkg::AMOUNT_W-1:0] rsp_entry_amount,
   input wire logic                                rsp_last
);

   // A response word follows an accepted command or ongoing work
   `SOL_ASSERT_IMP(a_rsp_has_cause, rsp_strobe, $past(busy) || $past(start),
      "orphan response word")

   // Non-list words carry zero entry fields and close the command
   `SOL_ASSERT_IMP(a_single_word_form, rsp_strobe && (rsp_status != sol_pkg::ST_ENTRY),
      rsp_last && (rsp_entry_client == '0) && (rsp_entry_amount == '0),
      "bad single response word")

   // List words stream back to back until the last one
   `SOL_ASSERT_NXT(a_list_streams,
      rsp_strobe && (rsp_status == sol_pkg::ST_ENTRY) && !rsp_last,
      rsp_strobe && (rsp_status == sol_pkg::ST_ENTRY), "gap in list stream")

   // The closing word shows with the block ready for the next command
   `SOL_ASSERT_IMP(a_ready_at_last, rsp_strobe && rsp_last, !busy, "busy with last word")

   // Busy only rises after a command is taken
   `SOL_ASSERT_IMP(a_busy_rise, $rose(busy), $past(start), "busy without command")

endmodule

bind sorted_order_list_core sol_checker u_sol_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_status       (rsp_status),
   .rsp_entry_client (rsp_entry_client),
   .rsp_entry_amount (rsp_entry_amount),
   .rsp_last         (rsp_last)
);

`default_nettype wire
